// File: design/sac_pkg.sv
package sac_pkg;

    localparam int MAX_LEDS    = 7;
    localparam int MAX_ASPECTS = 8;
    localparam int ROWS_PER_BANK = 4;
    localparam int ROW_BITS    = 2 * MAX_LEDS;
    localparam int BANK_BITS   = ROWS_PER_BANK * ROW_BITS;

    // Input item kinds
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_ACCESSORY = 2'd1;
    localparam logic [1:0] FUNC_EXTENDED = 2'd2;

    // LED action codes
    localparam logic [1:0] LED_OFF    = 2'd0;
    localparam logic [1:0] LED_ON     = 2'd1;
    localparam logic [1:0] LED_TOGGLE = 2'd2;
    localparam logic [1:0] LED_HOLD   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_COIL_MODE     = 3'd0;
    localparam logic [2:0] CFG_BASE_ADDRESS  = 3'd1;
    localparam logic [2:0] CFG_ADDRESS_COUNT = 3'd2;
    localparam logic [2:0] CFG_LED_COUNT     = 3'd3;
    localparam logic [2:0] CFG_BLINK         = 3'd4;
    localparam logic [2:0] CFG_PULSE         = 3'd5;
    localparam logic [2:0] CFG_PATTERNS_LOW  = 3'd6;
    localparam logic [2:0] CFG_PATTERNS_HIGH = 3'd7;

    localparam logic [7:0] ASPECT_ROW_MASK = 8'h7F;
    localparam logic [7:0] ASPECT_COIL_FLAG = 8'h80;

    typedef struct packed {
        logic                 coil_mode;
        logic [10:0]          base_address;
        logic [2:0]           address_count;
        logic [2:0]           led_count;
        logic [15:0]          blink_interval;
        logic [15:0]          coil_pulse_ticks;
        logic [BANK_BITS-1:0] patterns_low;
        logic [BANK_BITS-1:0] patterns_high;
    } t_cfg;

    typedef struct packed {
        logic [7:0]          current_aspect;
        logic [7:0]          fired_aspect;
        logic                idle_flag;
        logic [15:0]         elapsed_ticks;
        logic [MAX_LEDS-1:0] led_register;
        logic [1:0]          coil_register;
    } t_state;

    typedef struct packed {
        logic [MAX_LEDS-1:0] led_state;
        logic                coil_a;
        logic                coil_b;
        logic                ready_res;
        logic                address_hit;
    } t_result;

endpackage

// File: design/signal_aspect_controller_core.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// input    | in        | i_valid / o_stall       | i_func, i_dcc_address, i_dir, i_aspect_value
// result   | out       | o_valid / i_stall       | o_led_state, o_coil_a, o_coil_b,
//          |           |                         | o_ready_res, o_address_hit
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per clock while o_stall is low: the whole update of aspect, tick counter, LEDs
// and coils is one level of logic from the state registers, so a transfer can occur every
// cycle; its result is registered in the output register, or in the skid entry on a stall.
// A one-entry skid register keeps the input open for one more transfer while the
// result side stalls; o_stall rises only when that skid entry is occupied.
// Reset is synchronous, active low, and loads the register defaults and idle state.
// Configuration writes are always taken (o_cfg_ready is held high).
module signal_aspect_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [10:0] i_dcc_address,
    input  logic        i_dir,
    input  logic [7:0]  i_aspect_value,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [sac_pkg::MAX_LEDS-1:0] o_led_state,
    output logic        o_coil_a,
    output logic        o_coil_b,
    output logic        o_ready_res,
    output logic        o_address_hit,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [sac_pkg::BANK_BITS-1:0] i_cfg_data
);
    import sac_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    accept;
    logic    out_move;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign accept      = i_valid && !r_skid_valid;
    // Output register may load when empty or when its content is being taken.
    assign out_move    = !r_out_valid || !i_stall;

    sac_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_func         (i_func),
        .i_dcc_address  (i_dcc_address),
        .i_dir          (i_dir),
        .i_aspect_value (i_aspect_value),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coil_mode        <= 1'b0;
            r_cfg.base_address     <= 11'd1;
            r_cfg.address_count    <= 3'd1;
            r_cfg.led_count        <= 3'd0;
            r_cfg.blink_interval   <= 16'd500;
            r_cfg.coil_pulse_ticks <= 16'd100;
            r_cfg.patterns_low     <= '0;
            r_cfg.patterns_high    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COIL_MODE:     r_cfg.coil_mode        <= i_cfg_data[0];
                CFG_BASE_ADDRESS:  r_cfg.base_address     <= i_cfg_data[10:0];
                CFG_ADDRESS_COUNT: r_cfg.address_count    <= i_cfg_data[2:0];
                CFG_LED_COUNT:     r_cfg.led_count        <= i_cfg_data[2:0];
                CFG_BLINK:         r_cfg.blink_interval   <= i_cfg_data[15:0];
                CFG_PULSE:         r_cfg.coil_pulse_ticks <= i_cfg_data[15:0];
                CFG_PATTERNS_LOW:  r_cfg.patterns_low     <= i_cfg_data;
                CFG_PATTERNS_HIGH: r_cfg.patterns_high    <= i_cfg_data;
            endcase
        end
    end

    // Controller state: advance on every accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.current_aspect <= 8'd0;
            r_state.fired_aspect   <= 8'd0;
            r_state.idle_flag      <= 1'b1;
            r_state.elapsed_ticks  <= 16'd0;
            r_state.led_register   <= '0;
            r_state.coil_register  <= 2'b00;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register and skid entry: control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_move) begin
            // drain the skid entry first; a new transfer cannot coexist with it
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            // output held: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    // Output register and skid entry: payload
    always_ff @(posedge i_clk) begin
        if (out_move) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!out_move && accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_led_state   = r_out.led_state;
    assign o_coil_a      = r_out.coil_a;
    assign o_coil_b      = r_out.coil_b;
    assign o_ready_res   = r_out.ready_res;
    assign o_address_hit = r_out.address_hit;

endmodule

// File: design/sac_step.sv
module sac_step (
    input  sac_pkg::t_cfg    i_cfg,
    input  sac_pkg::t_state  i_state,
    input  logic [1:0]       i_func,
    input  logic [10:0]      i_dcc_address,
    input  logic             i_dir,
    input  logic [7:0]       i_aspect_value,
    output sac_pkg::t_state  o_state,
    output sac_pkg::t_result o_result
);
    import sac_pkg::*;

    logic [11:0]          addr_limit;
    logic [10:0]          addr_diff;
    logic                 in_range;
    logic [15:0]          ticks_inc;
    logic [6:0]           row;
    logic [BANK_BITS-1:0] bank;
    logic [ROW_BITS-1:0]  codes;
    logic [7:0]           accessory_aspect;
    logic                 hit;
    t_state               s;

    assign addr_limit = {1'b0, i_cfg.base_address} + {9'd0, i_cfg.address_count};
    assign addr_diff  = i_dcc_address - i_cfg.base_address;
    assign in_range   = (i_dcc_address >= i_cfg.base_address)
                        && ({1'b0, i_dcc_address} < addr_limit);
    assign accessory_aspect = {i_cfg.coil_mode, 3'd0, addr_diff[2:0], i_dir};
    assign ticks_inc  = (i_state.elapsed_ticks == 16'hFFFF) ? i_state.elapsed_ticks
                        : i_state.elapsed_ticks + 16'd1;
    assign row        = i_state.current_aspect[6:0];
    assign bank       = row[2] ? i_cfg.patterns_high : i_cfg.patterns_low;

    always_comb begin
        unique case (row[1:0])
            2'd0:    codes = bank[0*ROW_BITS +: ROW_BITS];
            2'd1:    codes = bank[1*ROW_BITS +: ROW_BITS];
            2'd2:    codes = bank[2*ROW_BITS +: ROW_BITS];
            default: codes = bank[3*ROW_BITS +: ROW_BITS];
        endcase
    end

    always_comb begin
        s   = i_state;
        hit = 1'b0;
        unique case (i_func)
            FUNC_TICK: begin
                if (i_cfg.coil_mode) begin
                    if (!s.idle_flag) begin
                        s.elapsed_ticks = ticks_inc;
                    end
                    if (s.idle_flag && (s.current_aspect != s.fired_aspect)) begin
                        s.current_aspect = {7'd0, s.current_aspect[0]};
                        s.fired_aspect   = s.current_aspect;
                        s.elapsed_ticks  = 16'd0;
                        s.idle_flag      = 1'b0;
                        s.coil_register  = s.current_aspect[0] ? 2'b01 : 2'b10;
                    end
                    if (!s.idle_flag && (s.elapsed_ticks >= i_cfg.coil_pulse_ticks)) begin
                        s.idle_flag      = 1'b1;
                        s.coil_register  = 2'b00;
                        s.current_aspect = {7'd0, s.current_aspect[0]};
                    end
                end else begin
                    s.elapsed_ticks = ticks_inc;
                    if (ticks_inc >= i_cfg.blink_interval) begin
                        s.elapsed_ticks = 16'd0;
                        if (row < 7'(MAX_ASPECTS)) begin
                            for (int i = 0; i < MAX_LEDS; i++) begin
                                if (3'(i) < i_cfg.led_count) begin
                                    unique case (codes[2*i +: 2])
                                        LED_OFF:    s.led_register[i] = 1'b0;
                                        LED_ON:     s.led_register[i] = 1'b1;
                                        LED_TOGGLE: s.led_register[i] = ~i_state.led_register[i];
                                        LED_HOLD:   s.led_register[i] = i_state.led_register[i];
                                    endcase
                                end
                            end
                        end
                    end
                end
            end
            FUNC_ACCESSORY: begin
                if (in_range) begin
                    s.current_aspect = accessory_aspect;
                    hit = 1'b1;
                end
            end
            FUNC_EXTENDED: begin
                if (i_dcc_address == i_cfg.base_address) begin
                    s.current_aspect = i_aspect_value;
                    hit = 1'b1;
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    assign o_state              = s;
    assign o_result.led_state   = s.led_register;
    assign o_result.coil_a      = s.coil_register[0];
    assign o_result.coil_b      = s.coil_register[1];
    assign o_result.ready_res   = i_cfg.coil_mode ? s.idle_flag : 1'b1;
    assign o_result.address_hit = hit;

endmodule

// File: design/sac_checker.sv
module sac_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [sac_pkg::MAX_LEDS-1:0] o_led_state,
    input  logic        o_coil_a,
    input  logic        o_coil_b,
    input  logic        o_ready_res,
    input  logic        o_address_hit
);
    import sac_pkg::*;

    // Never drive both coils
    a_coil_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_coil_a && o_coil_b))
        else $error("both coils energized");

    // Busy means a coil is energized
    a_busy_coil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready_res) |-> (o_coil_a || o_coil_b))
        else $error("busy without an energized coil");

    // Input stall only rises after a transfer taken while the result was stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && o_valid && i_stall))
        else $error("input stall raised without a parked result");

    // Stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_led_state) && $stable(o_coil_a)
                                  && $stable(o_coil_b) && $stable(o_address_hit)))
        else $error("stalled result changed");

endmodule

bind signal_aspect_controller_core sac_checker u_sac_checker (.*);

// File: bench/tb.sv
module tb;
    import sac_pkg::*;

    // func code 3 has no meaning; the block must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // give up after this many cycles in which no transfer of any kind happens
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] addr;
        logic        dir;
        logic [7:0]  value;
    } t_dcc_cmd;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_func         = FUNC_TICK;
    logic [10:0]          i_dcc_address  = '0;
    logic                 i_dir          = 1'b0;
    logic [7:0]           i_aspect_value = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [MAX_LEDS-1:0]  o_led_state;
    logic                 o_coil_a;
    logic                 o_coil_b;
    logic                 o_ready_res;
    logic                 o_address_hit;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index    = CFG_COIL_MODE;
    logic [BANK_BITS-1:0] i_cfg_data     = '0;

    signal_aspect_controller_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_dcc_address  (i_dcc_address),
        .i_dir          (i_dir),
        .i_aspect_value (i_aspect_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_led_state    (o_led_state),
        .o_coil_a       (o_coil_a),
        .o_coil_b       (o_coil_b),
        .o_ready_res    (o_ready_res),
        .o_address_hit  (o_address_hit),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Commands waiting to be driven, and the status words they must produce.
    t_dcc_cmd pending_cmds[$];
    t_result  expected_status[$];

    // Shadow of the register file and of the decoder state, kept in step
    // with every accepted transfer.
    t_cfg     shadow_cfg;
    t_state   decoder_state;

    // Drop all idling on both sides while this is set.
    bit       calm = 1'b0;

    int       err_count    = 0;
    int       status_seen  = 0;
    int       cmds_taken   = 0;
    int       hits_taken   = 0;
    int       coil_fires   = 0;
    int       led_refreshes = 0;
    int       setups_loaded = 0;
    int       quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Advance the blink counter; on expiry refresh every driven LED from the
    // code table row of the current aspect.
    function automatic void led_tick();
        logic [6:0]           row;
        logic [BANK_BITS-1:0] bank;
        logic [1:0]           code;
        int                   i;
        if (decoder_state.elapsed_ticks != 16'hFFFF)
            decoder_state.elapsed_ticks++;
        if (decoder_state.elapsed_ticks < shadow_cfg.blink_interval)
            return;
        decoder_state.elapsed_ticks = '0;
        led_refreshes++;
        row = 7'(decoder_state.current_aspect & ASPECT_ROW_MASK);
        // rows past the table leave every LED as it is
        if (row >= MAX_ASPECTS)
            return;
        bank = (row < ROWS_PER_BANK) ? shadow_cfg.patterns_low : shadow_cfg.patterns_high;
        bank = bank >> (int'(row[1:0]) * ROW_BITS);
        for (i = 0; i < MAX_LEDS; i++) begin
            if (i < int'(shadow_cfg.led_count)) begin
                code = bank[2*i +: 2];
                case (code)
                    LED_OFF:    decoder_state.led_register[i] = 1'b0;
                    LED_ON:     decoder_state.led_register[i] = 1'b1;
                    LED_TOGGLE: decoder_state.led_register[i] = ~decoder_state.led_register[i];
                    default:    ;
                endcase
            end
        end
    endfunction

    // Fire a coil when idle and the aspect moved; release it once the pulse
    // length has been counted out (possibly on the same tick).
    function automatic void coil_tick();
        if (!decoder_state.idle_flag && decoder_state.elapsed_ticks != 16'hFFFF)
            decoder_state.elapsed_ticks++;
        if (decoder_state.idle_flag &&
            decoder_state.current_aspect != decoder_state.fired_aspect) begin
            decoder_state.current_aspect &= 8'h01;
            decoder_state.fired_aspect  = decoder_state.current_aspect;
            decoder_state.elapsed_ticks = '0;
            decoder_state.idle_flag     = 1'b0;
            decoder_state.coil_register = decoder_state.current_aspect[0] ? 2'b01 : 2'b10;
            coil_fires++;
        end
        if (!decoder_state.idle_flag &&
            decoder_state.elapsed_ticks >= shadow_cfg.coil_pulse_ticks) begin
            decoder_state.idle_flag     = 1'b1;
            decoder_state.coil_register = 2'b00;
            decoder_state.current_aspect &= 8'h01;
        end
    endfunction

    // Apply one accepted command and return the status word it must produce.
    function automatic t_result apply_command(input t_dcc_cmd c);
        t_result     r;
        int unsigned addr_u;
        int unsigned base_u;
        logic [7:0]  aspect;
        addr_u        = c.addr;
        base_u        = shadow_cfg.base_address;
        r.address_hit = 1'b0;
        case (c.func)
            FUNC_TICK: begin
                if (shadow_cfg.coil_mode)
                    coil_tick();
                else
                    led_tick();
            end
            FUNC_ACCESSORY: begin
                if (addr_u >= base_u && addr_u < base_u + shadow_cfg.address_count) begin
                    aspect = 8'((addr_u - base_u) * 2 + c.dir);
                    if (shadow_cfg.coil_mode)
                        aspect = aspect | ASPECT_COIL_FLAG;
                    decoder_state.current_aspect = aspect;
                    r.address_hit = 1'b1;
                end
            end
            FUNC_EXTENDED: begin
                if (addr_u == base_u) begin
                    decoder_state.current_aspect = c.value;
                    r.address_hit = 1'b1;
                end
            end
            default: ;
        endcase
        if (r.address_hit)
            hits_taken++;
        r.led_state = decoder_state.led_register;
        r.coil_a    = decoder_state.coil_register[0];
        r.coil_b    = decoder_state.coil_register[1];
        r.ready_res = shadow_cfg.coil_mode ? decoder_state.idle_flag : 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [BANK_BITS-1:0] rand_bank();
        return BANK_BITS'({$urandom, $urandom});
    endfunction

    // Mostly ticks and commands aimed at the decoder's own addresses, so the
    // aspect keeps moving; the rest is foreign traffic and unused codes.
    function automatic t_dcc_cmd random_cmd();
        t_dcc_cmd    c;
        int unsigned pick;
        int unsigned span;
        pick    = $urandom_range(99);
        span    = shadow_cfg.address_count;
        c.func  = FUNC_TICK;
        c.addr  = 11'($urandom_range(2047));
        c.dir   = 1'($urandom_range(1));
        c.value = 8'($urandom);
        if (pick < 45) begin
            c.func = FUNC_TICK;
        end else if (pick < 70) begin
            c.func = FUNC_ACCESSORY;
            if (span != 0)
                c.addr = 11'(shadow_cfg.base_address + $urandom_range(span - 1));
        end else if (pick < 82) begin
            c.func  = FUNC_EXTENDED;
            c.addr  = shadow_cfg.base_address;
            // small aspects hit the table; now and then anything goes
            if ($urandom_range(3) != 0)
                c.value = 8'($urandom_range(9));
        end else if (pick < 92) begin
            c.func = FUNC_ACCESSORY;
        end else if (pick < 96) begin
            c.func = FUNC_EXTENDED;
        end else begin
            c.func = FUNC_UNUSED;
        end
        return c;
    endfunction

    task automatic queue_cmd(input logic [1:0] f, input logic [10:0] a, input logic d,
                             input logic [7:0] v);
        t_dcc_cmd c;
        c.func  = f;
        c.addr  = a;
        c.dir   = d;
        c.value = v;
        pending_cmds.push_back(c);
    endtask

    // Write one register and mirror it into the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [BANK_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COIL_MODE:     shadow_cfg.coil_mode        = data[0];
            CFG_BASE_ADDRESS:  shadow_cfg.base_address     = data[10:0];
            CFG_ADDRESS_COUNT: shadow_cfg.address_count    = data[2:0];
            CFG_LED_COUNT:     shadow_cfg.led_count        = data[2:0];
            CFG_BLINK:         shadow_cfg.blink_interval   = data[15:0];
            CFG_PULSE:         shadow_cfg.coil_pulse_ticks = data[15:0];
            CFG_PATTERNS_LOW:  shadow_cfg.patterns_low     = data;
            CFG_PATTERNS_HIGH: shadow_cfg.patterns_high    = data;
            default:           ;
        endcase
    endtask

    task automatic load_setup(input logic coil, input logic [10:0] base, input logic [2:0] span,
                              input logic [2:0] leds, input logic [15:0] blink,
                              input logic [15:0] pulse, input logic [BANK_BITS-1:0] lo,
                              input logic [BANK_BITS-1:0] hi);
        write_reg(CFG_COIL_MODE, BANK_BITS'(coil));
        write_reg(CFG_BASE_ADDRESS, BANK_BITS'(base));
        write_reg(CFG_ADDRESS_COUNT, BANK_BITS'(span));
        write_reg(CFG_LED_COUNT, BANK_BITS'(leds));
        write_reg(CFG_BLINK, BANK_BITS'(blink));
        write_reg(CFG_PULSE, BANK_BITS'(pulse));
        write_reg(CFG_PATTERNS_LOW, lo);
        write_reg(CFG_PATTERNS_HIGH, hi);
        setups_loaded++;
    endtask

    // Hold off until every queued command is accepted and every status word
    // has come back, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        repeat (n) pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    task automatic check_status();
        t_result want;
        if (expected_status.size() == 0) begin
            flag_mismatch($sformatf("status %0d arrived with no command outstanding",
                                    status_seen));
        end else begin
            want = expected_status.pop_front();
            if (o_led_state !== want.led_state)
                flag_mismatch($sformatf("status %0d led_state got %h want %h",
                                        status_seen, o_led_state, want.led_state));
            if (o_coil_a !== want.coil_a)
                flag_mismatch($sformatf("status %0d coil_a got %b want %b",
                                        status_seen, o_coil_a, want.coil_a));
            if (o_coil_b !== want.coil_b)
                flag_mismatch($sformatf("status %0d coil_b got %b want %b",
                                        status_seen, o_coil_b, want.coil_b));
            if (o_ready_res !== want.ready_res)
                flag_mismatch($sformatf("status %0d ready_res got %b want %b",
                                        status_seen, o_ready_res, want.ready_res));
            if (o_address_hit !== want.address_hit)
                flag_mismatch($sformatf("status %0d address_hit got %b want %b",
                                        status_seen, o_address_hit, want.address_hit));
        end
        status_seen++;
    endtask

    // ------------------------------------------------------------------
    // Command driver: predict on every accepted transfer, hold the payload
    // while stalled, otherwise present the next command or idle at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_status.push_back(apply_command(pending_cmds.pop_front()));
                cmds_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
                    i_valid        <= 1'b1;
                    i_func         <= pending_cmds[0].func;
                    i_dcc_address  <= pending_cmds[0].addr;
                    i_dir          <= pending_cmds[0].dir;
                    i_aspect_value <= pending_cmds[0].value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor: check each accepted transfer, stall at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_status();
            i_stall <= !calm && ($urandom_range(99) < 37);
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // reset values of the register file and the decoder
        shadow_cfg.coil_mode        = 1'b0;
        shadow_cfg.base_address     = 11'd1;
        shadow_cfg.address_count    = 3'd1;
        shadow_cfg.led_count        = 3'd0;
        shadow_cfg.blink_interval   = 16'd500;
        shadow_cfg.coil_pulse_ticks = 16'd100;
        shadow_cfg.patterns_low     = '0;
        shadow_cfg.patterns_high    = '0;
        decoder_state               = '0;
        decoder_state.idle_flag     = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Signal mode, refresh on every tick: hits, near misses on both sides
        // of the address window, rows past the table and the unused code.
        load_setup(1'b0, 11'd1, 3'd3, 3'd7, 16'd1, 16'd2, rand_bank(), rand_bank());
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_ACCESSORY, 11'd0,    1'b1, 8'd0);
        queue_cmd(FUNC_ACCESSORY, 11'd1,    1'b0, 8'd0);
        queue_cmd(FUNC_TICK,      11'd2047, 1'b1, 8'd255);
        queue_cmd(FUNC_ACCESSORY, 11'd3,    1'b1, 8'd0);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_ACCESSORY, 11'd4,    1'b0, 8'd0);
        queue_cmd(FUNC_EXTENDED,  11'd1,    1'b0, 8'd255);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_EXTENDED,  11'd1,    1'b1, 8'd7);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_EXTENDED,  11'd1,    1'b0, 8'd8);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_EXTENDED,  11'd2047, 1'b0, 8'd0);
        queue_cmd(FUNC_UNUSED,    11'd2047, 1'b1, 8'd255);
        queue_cmd(FUNC_ACCESSORY, 11'd2047, 1'b1, 8'd0);
        wait_drained();

        // Coil mode at the top address with a zero-length pulse: each coil
        // fires and releases on one tick.
        load_setup(1'b1, 11'd2047, 3'd1, 3'd0, 16'd500, 16'd0, '0, '0);
        queue_cmd(FUNC_EXTENDED,  11'd2047, 1'b0, 8'd1);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_ACCESSORY, 11'd2047, 1'b0, 8'd0);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_TICK,      11'd0,    1'b0, 8'd0);
        queue_cmd(FUNC_UNUSED,    11'd0,    1'b0, 8'd0);
        wait_drained();

        // Random phases; the first runs with no idling on either side.
        calm = 1'b1;
        load_setup(1'b0, 11'd0, 3'd4, 3'd7, 16'd1, 16'd100, rand_bank(), rand_bank());
        random_phase(190);
        calm = 1'b0;

        // zero blink interval, widest address window, extreme code tables
        load_setup(1'b0, 11'd2047, 3'd7, 3'd3, 16'd0, 16'd1, '1, '0);
        random_phase(190);

        load_setup(1'b1, 11'd100, 3'd2, 3'd0, 16'd3, 16'd0, '0, '1);
        random_phase(190);

        load_setup(1'b1, 11'd5, 3'd1, 3'd7, 16'd500, 16'd5, rand_bank(), rand_bank());
        random_phase(190);

        // empty address window: only extended commands can hit
        load_setup(1'b0, 11'd5, 3'd0, 3'd5, 16'd2, 16'd65535, rand_bank(), rand_bank());
        random_phase(190);

        // a pulse this long cannot end within this phase, so the coil is still on when the
        // next phase drops back to signal mode
        load_setup(1'b1, 11'd2040, 3'd4, 3'd2, 16'd65535, 16'd65535, rand_bank(), rand_bank());
        random_phase(190);

        load_setup(1'b0, 11'd2044, 3'd4, 3'd7, 16'd4, 16'd3, rand_bank(), rand_bank());
        random_phase(190);

        load_setup(1'b1, 11'd9, 3'd3, 3'd6, 16'd7, 16'd3, rand_bank(), rand_bank());
        random_phase(190);

        $display("Ran %0d commands through %0d register setups: %0d address hits,",
                 cmds_taken, setups_loaded, hits_taken);
        $display("%0d coil pulses, %0d LED refreshes, %0d status words checked, %0d errors",
                 coil_fires, led_refreshes, status_seen, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
design/sac_pkg.sv
design/sac_step.sv
design/signal_aspect_controller_core.sv
design/sac_checker.sv
bench/tb.sv
